// ----- src/uxf_pkg.sv -----
// uxf_pkg: shared types, codes and constants for the uart transmitter with fifo
// no dependencies, compiled first

package uxf_pkg;

   // action codes as they arrive on the request channel
   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_FLUSH  = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int          QUEUE_DEPTH_DEFAULT = 64;
   localparam logic [15:0] PERIOD_RESET        = 16'd767;
   localparam int          CMDQ_DEPTH          = 4;
   localparam int          COUNT_W             = 6;

   // bit position encoding of the frame
   localparam logic [3:0] START_POS      = 4'd0;
   localparam logic [3:0] FIRST_DATA_POS = 4'd1;
   localparam logic [3:0] LAST_DATA_POS  = 4'd8;
   localparam logic [3:0] STOP_POS       = 4'd9;

   typedef enum logic [1:0] {
      CMD_PUSH,
      CMD_FLUSH,
      CMD_TICK,
      CMD_NOP
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
   } cmd_word_type;

endpackage

// ----- src/uxf_channels.sv -----
// uxf_req_if and uxf_rsp_if: valid/ready channels for requests and responses
// depends on nothing but the port widths of the work items

interface uxf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

interface uxf_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic       line_level;
   logic       busy_res;
   logic [5:0] queued_count;

   modport source (output valid, accepted, line_level, busy_res, queued_count, input ready);
   modport sink   (input valid, accepted, line_level, busy_res, queued_count, output ready);
endinterface

// ----- src/uxf_transmitter_with_fifo_unit_top.sv -----
// order: a word waits in the front queue, then the back pops it and registers its response;
//   a byte-starting tick first passes the fetch state (registered read of the byte store)
// throughput: one word per cycle while the response slot is free and no fetch is running
// reset: synchronous, active high; clears indices, timer, frame state, queues and
//   response valid, line idles high, bit period returns to 767; store contents undefined
// depends on uxf_pkg, uxf_channels, uxf_front, uxf_back, uxf_period_reg

module uart_transmitter_with_fifo_unit #(
   parameter int QUEUE_DEPTH = uxf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   uxf_req_if.sink     req_if,
   uxf_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import uxf_pkg::*;

   // decoded words waiting for the executor
   logic         cmd_valid;
   cmd_word_type cmd_word;
   logic         cmd_pop;

   // bit period as last written
   logic [15:0]  period;

   // csr register, written only while the block is idle: binds the user, not enforced here
   uxf_period_reg u_period (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .period    (period)
   );

   // front: takes a word per cycle while its queue has room, classifies the action
   uxf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop)
   );

   // back: byte store, timer, shifter; pops only when the response slot is free
   uxf_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop),
      .period    (period),
      .rsp_if    (rsp_if)
   );

endmodule

// ----- src/uxf_front.sv -----
// uxf_front: accepts request words, decodes the action and holds them in a short queue
// depends on uxf_pkg and uxf_req_if

module uxf_front (
   input  logic                 clock,
   input  logic                 reset,
   uxf_req_if.sink              req_if,
   output logic                 cmd_valid,
   output uxf_pkg::cmd_word_type cmd_word,
   input  logic                 cmd_pop
);
   import uxf_pkg::*;

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_word_type             q_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]         cnt_ff;
   cmd_word_type             dec;
   logic                     push, pop;

   // classify the incoming action
   always_comb begin
      dec.data = req_if.data_byte;
      unique case (req_if.action)
         ACT_PUSH:   dec.op = CMD_PUSH;
         ACT_FLUSH:  dec.op = CMD_FLUSH;
         ACT_TICK:   dec.op = CMD_TICK;
         ACT_UNUSED: dec.op = CMD_NOP;
         default:    dec.op = CMD_NOP;
      endcase
   end

   assign req_if.ready = (cnt_ff != CNT_W'(CMDQ_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign cmd_valid    = (cnt_ff != '0);
   assign pop          = cmd_pop && cmd_valid;
   assign cmd_word     = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         unique case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + CNT_W'(1);
            2'b01:   cnt_ff <= cnt_ff - CNT_W'(1);
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CMDQ_DEPTH))
      else $error("command queue count beyond depth");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CNT_W'(CMDQ_DEPTH) && !cmd_pop) |=> cnt_ff == CNT_W'(CMDQ_DEPTH))
      else $error("full command queue changed without a pop");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - CNT_W'(1))
      else $error("pop did not reduce the count");

endmodule

// ----- src/uxf_back.sv -----
// uxf_back: executes commands: byte store, bit timer, 8n1 shifter and response register
// depends on uxf_pkg and uxf_rsp_if

module uxf_back #(
   parameter int QUEUE_DEPTH = uxf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  uxf_pkg::cmd_word_type cmd_word,
   output logic                 cmd_pop,
   input  logic [15:0]          period,
   uxf_rsp_if.source            rsp_if
);
   import uxf_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   typedef enum logic {S_EXEC, S_FETCH} state_type;

   logic [7:0]       mem [QUEUE_DEPTH];
   logic [7:0]       rd_data_ff;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in, rd_idx_ff, rd_idx_in;
   logic             sending_ff, sending_in;
   logic [7:0]       shift_ff, shift_in;
   logic [3:0]       bitpos_ff, bitpos_in;
   logic             pin_ff, pin_in;
   logic [15:0]      tick_ff, tick_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             acc_ff, level_ff, busy_ff;
   logic [5:0]       count_ff;

   logic             slot_free, rsp_load, mem_we, fetch_go, acc;
   logic [IDX_W-1:0] wr_next;
   logic [IDX_W:0]   diff;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
      advance = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign wr_next   = advance(wr_idx_ff);

   always_comb begin
      state_in   = state_ff;
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      sending_in = sending_ff;
      shift_in   = shift_ff;
      bitpos_in  = bitpos_ff;
      pin_in     = pin_ff;
      tick_in    = tick_ff;
      cmd_pop    = 1'b0;
      rsp_load   = 1'b0;
      mem_we     = 1'b0;
      fetch_go   = 1'b0;
      acc        = 1'b0;
      unique case (state_ff)
         S_EXEC: begin
            if (cmd_valid && slot_free) begin
               cmd_pop  = 1'b1;
               rsp_load = 1'b1;
               unique case (cmd_word.op)
                  CMD_PUSH: begin
                     if (wr_next != rd_idx_ff) begin
                        mem_we     = 1'b1;
                        wr_idx_in  = wr_next;
                        sending_in = 1'b1;
                        acc        = 1'b1;
                     end
                  end
                  CMD_FLUSH: begin
                     wr_idx_in  = '0;
                     rd_idx_in  = '0;
                     sending_in = 1'b0;
                  end
                  CMD_TICK: begin
                     if (tick_ff >= period) begin
                        tick_in = '0;
                        if (sending_ff) begin
                           priority if (bitpos_ff == START_POS) begin
                              if (wr_idx_ff != rd_idx_ff) begin
                                 fetch_go = 1'b1;
                                 rsp_load = 1'b0;
                                 state_in = S_FETCH;
                              end else begin
                                 sending_in = 1'b0;
                              end
                           end else if (bitpos_ff <= LAST_DATA_POS) begin
                              pin_in    = shift_ff[0];
                              shift_in  = {1'b0, shift_ff[7:1]};
                              bitpos_in = bitpos_ff + 4'd1;
                           end else begin
                              pin_in    = 1'b1;
                              bitpos_in = START_POS;
                           end
                        end
                     end else begin
                        tick_in = tick_ff + 16'd1;
                     end
                  end
                  CMD_NOP: begin
                  end
               endcase
            end
         end
         S_FETCH: begin
            state_in  = S_EXEC;
            rsp_load  = 1'b1;
            shift_in  = rd_data_ff;
            rd_idx_in = advance(rd_idx_ff);
            pin_in    = 1'b0;
            bitpos_in = FIRST_DATA_POS;
         end
      endcase

      if (rsp_load)          rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   // occupancy after this word, modulo the store depth
   assign diff = (wr_idx_in >= rd_idx_in)
               ? {1'b0, wr_idx_in} - {1'b0, rd_idx_in}
               : {1'b0, wr_idx_in} + (IDX_W+1)'(QUEUE_DEPTH) - {1'b0, rd_idx_in};

   // byte store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx_ff] <= cmd_word.data;
      end
      if (fetch_go) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_EXEC;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         sending_ff   <= 1'b0;
         shift_ff     <= '0;
         bitpos_ff    <= START_POS;
         pin_ff       <= 1'b1;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         sending_ff   <= sending_in;
         shift_ff     <= shift_in;
         bitpos_ff    <= bitpos_in;
         pin_ff       <= pin_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         acc_ff   <= acc;
         level_ff <= pin_in;
         busy_ff  <= sending_in;
         count_ff <= COUNT_W'(diff);
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.accepted     = acc_ff;
   assign rsp_if.line_level   = level_ff;
   assign rsp_if.busy_res     = busy_ff;
   assign rsp_if.queued_count = count_ff;

   a_fetch_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> !rsp_valid_ff)
      else $error("response register busy during fetch");

   a_fetch_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> wr_idx_ff != rd_idx_ff)
      else $error("fetch from an empty store");

   a_idle_pin_high: assert property (@(posedge clock) disable iff (reset)
      bitpos_ff == START_POS |-> pin_ff)
      else $error("line low at a byte boundary");

   a_bitpos_range: assert property (@(posedge clock) disable iff (reset)
      bitpos_ff <= STOP_POS)
      else $error("bit position beyond stop bit");

endmodule

// ----- src/uxf_top_dummy_guard.sv -----
// uxf_period_reg: holds the bit period register written through the csr port
// depends on uxf_pkg

module uxf_period_reg (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output logic [15:0] period
);
   import uxf_pkg::*;

   logic [15:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         period_ff <= csr_wdata;
      end
   end

   assign period = period_ff;

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for uart_transmitter_with_fifo_unit: random and directed words
// checked against a cycle-free prediction of the 8n1 transmitter and its ring queue
// depends on uxf_pkg, uxf_channels and the unit's rtl

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import uxf_pkg::*;

   localparam int DEPTH       = QUEUE_DEPTH_DEFAULT;
   localparam int HOLD_CYCLES = 60;

   // one status word as the unit reports it
   typedef struct packed {
      logic       accepted;
      logic       line_level;
      logic       busy;
      logic [5:0] count;
   } tx_status_type;

   // one request word waiting for the driver
   typedef struct {
      logic [1:0] action;
      logic [7:0] data;
   } tx_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [15:0] csr_wdata;

   uxf_req_if req_bus ();
   uxf_rsp_if rsp_bus ();

   uart_transmitter_with_fifo_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // words still to be offered, and the statuses the unit still owes us
   tx_word_type   pending_words[$];
   tx_status_type status_due[$];

   int unsigned words_issued;
   int unsigned words_accepted;
   int unsigned results_checked;
   int unsigned mismatches;

   // handshake flags seen at the last rising edge, used by the falling-edge drivers
   logic req_fired;
   logic rsp_fired;

   // idling control; calm flags and hold-off request are set by the stimulus process
   bit src_calm;
   bit sink_calm;
   bit hold_off_request;
   bit sink_hold;
   int send_gap;
   int take_gap;
   tx_word_type next_word;

   // predicted transmitter state
   logic [7:0]  model_mem [DEPTH];
   int unsigned model_wr;
   int unsigned model_rd;
   bit          model_sending;
   logic [7:0]  model_shift;
   logic [3:0]  model_pos;
   logic        model_pin;
   logic [15:0] model_ticks;
   logic [15:0] model_period;

   // coverage tallies for the summary
   int unsigned pushes_stored;
   int unsigned pushes_refused;
   int unsigned flush_count;
   int unsigned bit_events;
   int unsigned frames_done;
   int unsigned periods_used;

   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 5);
   endfunction

   // one bit event on a compare match: start, data (lsb first), stop, or go idle
   function automatic void run_bit_event();
      if (!model_sending) return;
      bit_events++;
      if (model_pos == START_POS) begin
         if (model_wr != model_rd) begin
            model_shift = model_mem[model_rd];
            model_rd    = (model_rd + 1) % DEPTH;
            model_pin   = 1'b0;
            model_pos   = FIRST_DATA_POS;
         end else begin
            // empty queue at a byte boundary: stop sending, pin untouched
            model_sending = 1'b0;
         end
      end else if (model_pos <= LAST_DATA_POS) begin
         model_pin   = model_shift[0];
         model_shift = model_shift >> 1;
         model_pos   = model_pos + 4'd1;
      end else begin
         // stop bit, positions above nine fall here too
         model_pin = 1'b1;
         model_pos = START_POS;
         frames_done++;
      end
   endfunction

   // status after one accepted request word
   function automatic tx_status_type transmitter_status(logic [1:0] action, logic [7:0] data);
      tx_status_type st;
      int unsigned next_wr;
      st.accepted = 1'b0;
      next_wr = (model_wr + 1) % DEPTH;
      case (action)
         ACT_PUSH: begin
            if (next_wr != model_rd) begin
               model_mem[model_wr] = data;
               model_wr      = next_wr;
               model_sending = 1'b1;
               st.accepted   = 1'b1;
               pushes_stored++;
            end else begin
               pushes_refused++;
            end
         end
         ACT_FLUSH: begin
            // frame position, shifter, pin and timer are kept
            model_wr      = 0;
            model_rd      = 0;
            model_sending = 1'b0;
            flush_count++;
         end
         ACT_TICK: begin
            if (model_ticks >= model_period) begin
               model_ticks = '0;
               run_bit_event();
            end else begin
               model_ticks = model_ticks + 16'd1;
            end
         end
         default: ;
      endcase
      st.line_level = model_pin;
      st.busy       = model_sending;
      st.count      = 6'((model_wr + DEPTH - model_rd) % DEPTH);
      return st;
   endfunction

   task automatic log_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // monitor: tracks both handshakes, predicts on accepted requests, checks responses
   always @(posedge clock) begin : monitor
      tx_status_type got;
      tx_status_type want;
      if (reset) begin
         req_fired     <= 1'b0;
         rsp_fired     <= 1'b0;
         model_wr      = 0;
         model_rd      = 0;
         model_sending = 1'b0;
         model_shift   = '0;
         model_pos     = START_POS;
         model_pin     = 1'b1;
         model_ticks   = '0;
         model_period  = PERIOD_RESET;
      end else begin
         req_fired <= req_bus.valid && req_bus.ready;
         rsp_fired <= rsp_bus.valid && rsp_bus.ready;
         if (csr_we) model_period = csr_wdata;
         // responses always trail their requests, so checking first is safe
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.accepted, rsp_bus.line_level, rsp_bus.busy_res,
                   rsp_bus.queued_count};
            results_checked++;
            if (status_due.size() == 0) begin
               log_failure($sformatf("unexpected word: acc=%b line=%b busy=%b count=%0d",
                                     got.accepted, got.line_level, got.busy, got.count));
            end else begin
               want = status_due.pop_front();
               if (got !== want)
                  log_failure($sformatf({"mismatch: expected acc=%b line=%b busy=%b ",
                                         "count=%0d, got acc=%b line=%b busy=%b count=%0d"},
                                        want.accepted, want.line_level, want.busy,
                                        want.count, got.accepted, got.line_level,
                                        got.busy, got.count));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            status_due.push_back(transmitter_status(req_bus.action, req_bus.data_byte));
            words_accepted++;
         end
      end
   end

   // request driver: offers one word at a time, with a random gap after each one unless calm
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.action    <= ACT_TICK;
         req_bus.data_byte <= 8'h00;
      end else if (!req_bus.valid || req_fired) begin
         if (send_gap != 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            req_bus.action    <= next_word.action;
            req_bus.data_byte <= next_word.data;
            req_bus.valid     <= 1'b1;
            send_gap = draw_gap(src_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted in cycles on its own
   initial begin : hold_off
      wait (hold_off_request);
      @(posedge clock);
      sink_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      sink_hold = 1'b0;
   end

   // response side: random stalls per word, held off while the long stall runs
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (sink_hold) begin
         rsp_bus.ready <= 1'b0;
      end else if (!rsp_bus.ready || rsp_fired) begin
         if (take_gap != 0) begin
            take_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            take_gap = draw_gap(sink_calm);
         end
      end
   end

   task automatic add_word(logic [1:0] action, logic [7:0] data);
      tx_word_type w;
      w.action = action;
      w.data   = data;
      pending_words.push_back(w);
      words_issued++;
   endtask

   // random mix: pushes and flushes by percentage, a few unused codes, ticks for the rest
   task automatic run_mix(int n, int push_pct, int flush_pct);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < push_pct)
            add_word(ACT_PUSH, 8'($urandom_range(0, 255)));
         else if (r < push_pct + flush_pct)
            add_word(ACT_FLUSH, 8'($urandom_range(0, 255)));
         else if (r < push_pct + flush_pct + 3)
            add_word(ACT_UNUSED, 8'($urandom_range(0, 255)));
         else
            add_word(ACT_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   // wait until every word is in and every status is out, then let the pipeline settle
   task automatic settle();
      do @(negedge clock);
      while (words_accepted != words_issued || status_due.size() != 0);
      repeat (4) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic set_period(logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      periods_used++;
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      csr_we            = 1'b0;
      csr_wdata         = 16'h0000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset bit period: extremes of the byte, unused code, flush while busy
      periods_used = 1;
      add_word(ACT_PUSH, 8'h00);
      add_word(ACT_PUSH, 8'hFF);
      add_word(ACT_UNUSED, 8'hA5);
      add_word(ACT_TICK, 8'h00);
      add_word(ACT_PUSH, 8'h81);
      add_word(ACT_FLUSH, 8'h7E);
      add_word(ACT_TICK, 8'hFF);
      settle();

      // directed, event on every tick: a full frame then idle, flush mid-byte and resume
      set_period(16'h0000);
      add_word(ACT_PUSH, 8'h5A);
      repeat (11) add_word(ACT_TICK, 8'h00);
      add_word(ACT_PUSH, 8'h3C);
      repeat (3) add_word(ACT_TICK, 8'hFF);
      add_word(ACT_FLUSH, 8'h00);
      add_word(ACT_TICK, 8'h00);
      add_word(ACT_PUSH, 8'hC3);
      add_word(ACT_TICK, 8'h00);
      settle();

      // random at the fastest rate
      run_mix(160, 25, 3);
      settle();

      // overfill so pushes get refused, then drain with a push-heavy mix
      repeat (70) add_word(ACT_PUSH, 8'($urandom_range(0, 255)));
      run_mix(80, 35, 2);
      settle();

      // long receiver hold-off with a busy sender so the unit backs up
      set_period(16'h0001);
      src_calm         = 1'b1;
      hold_off_request = 1'b1;
      run_mix(120, 20, 3);
      settle();
      src_calm = 1'b0;

      // slowest period, no idling on either side
      set_period(16'hFFFF);
      src_calm  = 1'b1;
      sink_calm = 1'b1;
      run_mix(50, 30, 5);
      settle();
      src_calm  = 1'b0;
      sink_calm = 1'b0;

      // a small random period; the timer is usually past it already
      set_period(16'($urandom_range(2, 12)));
      run_mix(120, 15, 2);
      settle();

      $display("covered %0d words over %0d bit periods: %0d bytes stored, %0d refused, %0d flushes",
               words_accepted, periods_used, pushes_stored, pushes_refused, flush_count);
      $display("%0d bit events, %0d complete frames, %0d results checked, %0d mismatches",
               bit_events, frames_done, results_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASS uart_transmitter_with_fifo_unit");
      end else begin
         $display("FAIL uart_transmitter_with_fifo_unit");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("timeout: %0d words issued, %0d accepted, %0d results still due",
               words_issued, words_accepted, status_due.size());
      $display("FAIL uart_transmitter_with_fifo_unit");
      $finish;
   end

endmodule
